// File: rtl/psts_pkg.sv
// ----------------------------------------------------------------------------
// psts_pkg: shared definitions for the per-symbol target set table
// command codes, slot modes, stream layout and controller/datapath links
// ----------------------------------------------------------------------------
package psts_pkg;

    // default sizes
    localparam int SYMBOLS_DEF            = 256;
    localparam int TARGETS_PER_SYMBOL_DEF = 16;
    localparam int MARKERS_PER_SYMBOL_DEF = 8;

    // stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 88;

    // command codes
    localparam logic [2:0] CMD_ADD_TARGET  = 3'd0;
    localparam logic [2:0] CMD_ADD_MARKER  = 3'd1;
    localparam logic [2:0] CMD_CLR_SYMBOL  = 3'd2;
    localparam logic [2:0] CMD_CLR_MARKERS = 3'd3;
    localparam logic [2:0] CMD_RD_TARGET   = 3'd4;
    localparam logic [2:0] CMD_RD_MARKER   = 3'd5;

    // slot modes
    localparam logic [1:0] MODE_EMPTY  = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_MULTI  = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_META,
        ST_DEC,
        ST_SCAN,
        ST_COMMIT,
        ST_RDW,
        ST_WB,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic load_meta;
        logic dec;
        logic scan;
        logic commit;
        logic rd_cap;
        logic wb;
        logic out_load;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic       clr_done;
        logic       in_range;
        logic [2:0] cmd;
        logic       kind_bad;
        logic       scan_done;
        logic       out_free;
    } sts_t;

endpackage

// File: rtl/psts_datapath.sv
// ----------------------------------------------------------------------------
// psts_datapath: slot tables, element stores and result register
// holds per-slot mode and fill counts, the target and marker stores,
// the duplicate scan and the output stage
// ----------------------------------------------------------------------------
module psts_datapath #(
    parameter int SYMBOLS            = psts_pkg::SYMBOLS_DEF,
    parameter int TARGETS_PER_SYMBOL = psts_pkg::TARGETS_PER_SYMBOL_DEF,
    parameter int MARKERS_PER_SYMBOL = psts_pkg::MARKERS_PER_SYMBOL_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [psts_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [psts_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  psts_pkg::ctl_t                       ctl,
    output psts_pkg::sts_t                       sts
);

    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int TI_W   = $clog2(TARGETS_PER_SYMBOL);
    localparam int MI_W   = (MARKERS_PER_SYMBOL > 1) ? $clog2(MARKERS_PER_SYMBOL) : 1;
    localparam int TF_W   = $clog2(TARGETS_PER_SYMBOL + 1);
    localparam int MF_W   = $clog2(MARKERS_PER_SYMBOL + 1);
    localparam int SC_W   = (TF_W > MF_W) ? TF_W : MF_W;
    localparam int TOT_W  = $clog2(SYMBOLS + 1);
    localparam int META_W = 2 + TF_W + MF_W;
    localparam int TDEPTH = SYMBOLS * (2 ** TI_W);
    localparam int MDEPTH = SYMBOLS * (2 ** MI_W);

    // item registers
    logic [2:0]  cmd_reg;
    logic [7:0]  symbol_reg;
    logic [15:0] target_reg;
    logic [15:0] pattern_reg;
    logic [31:0] uid_reg;
    logic [7:0]  kind_reg;
    logic [3:0]  idx_reg;

    // slot table
    logic [META_W-1:0] meta_mem [SYMBOLS];
    logic [META_W-1:0] meta_q_reg;
    logic [SYM_W-1:0]  clr_reg;
    logic [1:0]        mode_reg, mode_next;
    logic [TF_W-1:0]   tfill_reg, tfill_next;
    logic [MF_W-1:0]   mfill_reg, mfill_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    // element stores
    logic [15:0] tmem [TDEPTH];
    logic [48:0] mmem [MDEPTH];
    logic [15:0] tq_reg;
    logic [48:0] mq_reg;

    // scan state
    logic [SC_W-1:0] scan_reg, scan_next;
    logic            pend_reg, pend_next;
    logic            hit_reg, hit_next;

    // result
    logic        ok_reg, ok_next;
    logic [15:0] rt_reg, rt_next;
    logic [15:0] rp_reg, rp_next;
    logic [31:0] ru_reg, ru_next;
    logic        rk_reg, rk_next;
    logic        out_valid_reg;
    logic [psts_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [SYM_W-1:0]       sym_a;
    logic                   in_range;
    logic                   is_rd;
    logic [31:0]            elem32;
    logic [SYM_W+TI_W-1:0]  taddr, twaddr;
    logic [SYM_W+MI_W-1:0]  maddr, mwaddr;
    logic [SC_W-1:0]        scan_lim;
    logic                   scan_more;
    logic                   match;
    logic                   t_full, m_full;
    logic [31:0]            tcount_rd, mcount_rd;
    logic                   rd_ok;
    logic [31:0]            count32;
    logic                   multi_out;
    logic [META_W-1:0]      meta_wdata;
    logic [SYM_W-1:0]       meta_waddr;

    // address and compare logic
    assign sym_a     = SYM_W'({24'd0, symbol_reg});
    assign in_range  = {24'd0, symbol_reg} < 32'(SYMBOLS);
    assign is_rd     = (cmd_reg == psts_pkg::CMD_RD_TARGET) ||
                       (cmd_reg == psts_pkg::CMD_RD_MARKER);
    assign elem32    = is_rd ? {28'd0, idx_reg} : 32'(scan_reg);
    assign taddr     = {sym_a, TI_W'(elem32)};
    assign maddr     = {sym_a, MI_W'(elem32)};
    assign twaddr    = {sym_a, TI_W'(32'(tfill_reg))};
    assign mwaddr    = {sym_a, MI_W'(32'(mfill_reg))};
    assign scan_lim  = (cmd_reg == psts_pkg::CMD_ADD_TARGET) ? SC_W'(tfill_reg)
                                                             : SC_W'(mfill_reg);
    assign scan_more = scan_reg < scan_lim;
    assign match     = (cmd_reg == psts_pkg::CMD_ADD_TARGET) ? (tq_reg == target_reg)
                     : (mq_reg == {kind_reg[0], uid_reg, pattern_reg});
    assign t_full    = 32'(tfill_reg) >= 32'(TARGETS_PER_SYMBOL);
    assign m_full    = 32'(mfill_reg) >= 32'(MARKERS_PER_SYMBOL);
    assign tcount_rd = (mode_reg == psts_pkg::MODE_EMPTY) ? 32'd0 : 32'(tfill_reg);
    assign mcount_rd = (mode_reg == psts_pkg::MODE_MULTI) ? 32'(mfill_reg) : 32'd0;
    assign rd_ok     = {28'd0, idx_reg} <
                       ((cmd_reg == psts_pkg::CMD_RD_TARGET) ? tcount_rd : mcount_rd);

    // status
    assign sts.clr_done  = 32'(clr_reg) == 32'(SYMBOLS - 1);
    assign sts.in_range  = in_range;
    assign sts.cmd       = cmd_reg;
    assign sts.kind_bad  = kind_reg > 8'd1;
    assign sts.scan_done = !scan_more && !pend_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= s_tdata[2:0];
            symbol_reg  <= s_tdata[10:3];
            target_reg  <= s_tdata[26:11];
            pattern_reg <= s_tdata[42:27];
            uid_reg     <= s_tdata[74:43];
            kind_reg    <= s_tdata[82:75];
            idx_reg     <= s_tdata[86:83];
        end
    end

    // slot table port
    assign meta_waddr = ctl.clr ? clr_reg : sym_a;
    assign meta_wdata = ctl.clr ? '0 : {mode_reg, tfill_reg, mfill_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.clr || ctl.wb)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q_reg <= meta_mem[sym_a];
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr)
        begin
            clr_reg <= clr_reg + SYM_W'(1);
        end
    end

    // element stores
    always_ff @(posedge clk)
    begin
        if (ctl.commit && (cmd_reg == psts_pkg::CMD_ADD_TARGET) && !hit_reg && !t_full)
        begin
            tmem[twaddr] <= target_reg;
        end
        if (ctl.commit && (cmd_reg == psts_pkg::CMD_ADD_MARKER) && !hit_reg && !m_full)
        begin
            mmem[mwaddr] <= {kind_reg[0], uid_reg, pattern_reg};
        end
        tq_reg <= tmem[taddr];
        mq_reg <= mmem[maddr];
    end

    // slot state, scan and result next values
    always_comb
    begin
        mode_next  = mode_reg;
        tfill_next = tfill_reg;
        mfill_next = mfill_reg;
        total_next = total_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        ok_next    = ok_reg;
        rt_next    = rt_reg;
        rp_next    = rp_reg;
        ru_next    = ru_reg;
        rk_next    = rk_reg;

        if (ctl.load)
        begin
            scan_next = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
            ok_next   = 1'b0;
            rt_next   = '0;
            rp_next   = '0;
            ru_next   = '0;
            rk_next   = 1'b0;
        end

        if (ctl.load_meta)
        begin
            {mode_next, tfill_next, mfill_next} = meta_q_reg;
        end

        // upgrades and clears decided once the slot is known
        if (ctl.dec)
        begin
            case (cmd_reg)
                psts_pkg::CMD_ADD_MARKER:
                begin
                    if (mode_reg != psts_pkg::MODE_MULTI)
                    begin
                        if (mode_reg == psts_pkg::MODE_EMPTY)
                        begin
                            tfill_next = '0;
                        end
                        mfill_next = '0;
                        mode_next  = psts_pkg::MODE_MULTI;
                        total_next = total_reg + TOT_W'(1);
                    end
                end
                psts_pkg::CMD_CLR_SYMBOL:
                begin
                    if (mode_reg == psts_pkg::MODE_MULTI)
                    begin
                        total_next = total_reg - TOT_W'(1);
                    end
                    mode_next  = psts_pkg::MODE_EMPTY;
                    tfill_next = '0;
                    mfill_next = '0;
                    ok_next    = 1'b1;
                end
                psts_pkg::CMD_CLR_MARKERS:
                begin
                    if (mode_reg == psts_pkg::MODE_MULTI)
                    begin
                        mfill_next = '0;
                    end
                    ok_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // duplicate scan, one stored element a cycle
        if (ctl.scan)
        begin
            pend_next = scan_more;
            if (scan_more)
            begin
                scan_next = scan_reg + SC_W'(1);
            end
            if (pend_reg && match)
            begin
                hit_next = 1'b1;
            end
        end

        // append when new and not full
        if (ctl.commit)
        begin
            if (cmd_reg == psts_pkg::CMD_ADD_TARGET)
            begin
                ok_next = hit_reg || !t_full;
                if (!hit_reg && !t_full)
                begin
                    tfill_next = tfill_reg + TF_W'(1);
                    if (mode_reg == psts_pkg::MODE_EMPTY)
                    begin
                        mode_next = psts_pkg::MODE_SINGLE;
                    end
                    else if (mode_reg == psts_pkg::MODE_SINGLE)
                    begin
                        mode_next  = psts_pkg::MODE_MULTI;
                        mfill_next = '0;
                        total_next = total_reg + TOT_W'(1);
                    end
                end
            end
            else
            begin
                ok_next = hit_reg || !m_full;
                if (!hit_reg && !m_full)
                begin
                    mfill_next = mfill_reg + MF_W'(1);
                end
            end
        end

        // read capture
        if (ctl.rd_cap)
        begin
            ok_next = rd_ok;
            if (rd_ok && (cmd_reg == psts_pkg::CMD_RD_TARGET))
            begin
                rt_next = tq_reg;
            end
            if (rd_ok && (cmd_reg == psts_pkg::CMD_RD_MARKER))
            begin
                rp_next = mq_reg[15:0];
                ru_next = mq_reg[47:16];
                rk_next = mq_reg[48];
            end
        end
    end

    // slot state registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        tfill_reg <= tfill_next;
        mfill_reg <= mfill_next;
        ok_reg    <= ok_next;
        rt_reg    <= rt_next;
        rp_reg    <= rp_next;
        ru_reg    <= ru_next;
        rk_reg    <= rk_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    // reported count per command
    always_comb
    begin
        case (cmd_reg)
            psts_pkg::CMD_ADD_TARGET: count32 = 32'(tfill_reg);
            psts_pkg::CMD_ADD_MARKER: count32 = 32'(mfill_reg);
            psts_pkg::CMD_RD_TARGET:  count32 = tcount_rd;
            psts_pkg::CMD_RD_MARKER:  count32 = mcount_rd;
            default:                  count32 = 32'd0;
        endcase
        if (!in_range)
        begin
            count32 = 32'd0;
        end
    end

    assign multi_out = in_range && (mode_reg == psts_pkg::MODE_MULTI);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= {7'd0, 9'(32'(total_reg)), multi_out, rk_reg, ru_reg,
                             rp_reg, rt_reg, 5'(count32), ok_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // multi count never passes the number of slots
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(SYMBOLS))
        else $error("multi slot count out of range");

    // a pending compare only follows a scan cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ctl.scan))
        else $error("compare pending without scan");

    // a result is only loaded into a free output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");

    // scan never runs past the list bound
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan |-> (32'(scan_reg) <= 32'(TARGETS_PER_SYMBOL)))
        else $error("scan past end");
`endif

endmodule

// File: rtl/psts_ctrl.sv
// ----------------------------------------------------------------------------
// psts_ctrl: sequencer for the per-symbol target set table
// runs the clearing pass, then steps each request through slot lookup and,
// by command, scan, append and write-back, clear and write-back, or read, then result
// ----------------------------------------------------------------------------
module psts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output psts_pkg::ctl_t ctl,
    input  psts_pkg::sts_t sts
);

    psts_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psts_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        ctl        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            psts_pkg::ST_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = psts_pkg::ST_IDLE;
                end
            end
            psts_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = psts_pkg::ST_LOAD;
                end
            end
            psts_pkg::ST_LOAD:
            begin
                state_next = psts_pkg::ST_META;
            end
            psts_pkg::ST_META:
            begin
                ctl.load_meta = 1'b1;
                state_next    = psts_pkg::ST_DEC;
            end
            psts_pkg::ST_DEC:
            begin
                state_next = psts_pkg::ST_DONE;
                if (sts.in_range)
                begin
                    case (sts.cmd)
                        psts_pkg::CMD_ADD_TARGET:
                        begin
                            state_next = psts_pkg::ST_SCAN;
                        end
                        psts_pkg::CMD_ADD_MARKER:
                        begin
                            if (!sts.kind_bad)
                            begin
                                ctl.dec    = 1'b1;
                                state_next = psts_pkg::ST_SCAN;
                            end
                        end
                        psts_pkg::CMD_CLR_SYMBOL,
                        psts_pkg::CMD_CLR_MARKERS:
                        begin
                            ctl.dec    = 1'b1;
                            state_next = psts_pkg::ST_WB;
                        end
                        psts_pkg::CMD_RD_TARGET,
                        psts_pkg::CMD_RD_MARKER:
                        begin
                            state_next = psts_pkg::ST_RDW;
                        end
                        default:
                        begin
                            state_next = psts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            psts_pkg::ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = psts_pkg::ST_COMMIT;
                end
            end
            psts_pkg::ST_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = psts_pkg::ST_WB;
            end
            psts_pkg::ST_RDW:
            begin
                ctl.rd_cap = 1'b1;
                state_next = psts_pkg::ST_DONE;
            end
            psts_pkg::ST_WB:
            begin
                ctl.wb     = 1'b1;
                state_next = psts_pkg::ST_DONE;
            end
            psts_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = psts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/per_symbol_target_set_table.sv
// ----------------------------------------------------------------------------
// per_symbol_target_set_table: per-symbol deduplicated target and marker sets
//
//   channel   dir  width  carries
//   s_*       in   88     one request: command, slot, target, marker, index
//   m_*       out  88     one result per request
//
// an add request runs a duplicate scan over the target or marker store, one
// element a cycle, before the next request is accepted; clears, reads, bad
// kinds and unknown commands skip the scan
// after reset a clearing pass over every slot empties the slot table;
// s_tready stays low until it ends
// a result waiting in the output register does not block the next request;
// only its final step waits for m_tready
// ----------------------------------------------------------------------------
module per_symbol_target_set_table #(
    parameter int SYMBOLS            = psts_pkg::SYMBOLS_DEF,
    parameter int TARGETS_PER_SYMBOL = psts_pkg::TARGETS_PER_SYMBOL_DEF,
    parameter int MARKERS_PER_SYMBOL = psts_pkg::MARKERS_PER_SYMBOL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command[2:0], symbol[10:3], target_value[26:11], pattern[42:27],
    // marker_uid[74:43], marker_kind[82:75], element_index[86:83], zero[87]
    input  logic [psts_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok[0], count[5:1], read_target[21:6], read_pattern[37:22],
    // read_uid[69:38], read_kind[70], is_multi[71], multi_entries[80:72],
    // zero[87:81]
    output logic [psts_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    psts_pkg::ctl_t ctl;
    psts_pkg::sts_t sts;

    // sequencer
    psts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // tables, stores and output stage
    psts_datapath #(
        .SYMBOLS            (SYMBOLS),
        .TARGETS_PER_SYMBOL (TARGETS_PER_SYMBOL),
        .MARKERS_PER_SYMBOL (MARKERS_PER_SYMBOL)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule

// File: test/per_symbol_target_set_table_test.sv
// ----------------------------------------------------------------------------
// per_symbol_target_set_table_test: self-checking bench for the target set table
// drives requests on the input stream, predicts each result from a local copy
// of the slot table and compares every field of every result in order
// ----------------------------------------------------------------------------
module per_symbol_target_set_table_test;

    localparam int NSYM = 256;
    localparam int NTGT = 16;
    localparam int NMRK = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]  element_index;
        logic [7:0]  marker_kind;
        logic [31:0] marker_uid;
        logic [15:0] pattern;
        logic [15:0] target_value;
        logic [7:0]  symbol;
        logic [2:0]  command;
    } request_t;

    typedef struct packed {
        logic [8:0]  multi_entries;
        logic        is_multi;
        logic        read_kind;
        logic [31:0] read_uid;
        logic [15:0] read_pattern;
        logic [15:0] read_target;
        logic [4:0]  count;
        logic        ok;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [psts_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [psts_pkg::OUT_TDATA_W-1:0] m_tdata;

    // local copy of the slot table
    logic [1:0]  mode_tab [NSYM];
    logic [15:0] tgt_tab [NSYM][NTGT];
    int          tgt_cnt [NSYM];
    logic [15:0] mrk_pat [NSYM][NMRK];
    logic [31:0] mrk_uid [NSYM][NMRK];
    logic        mrk_knd [NSYM][NMRK];
    int          mrk_cnt [NSYM];
    int          multi_cnt;

    answer_t expected_answers [$];
    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_off = 1'b0;

    per_symbol_target_set_table DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // turn a slot into multi mode
    function automatic void upgrade_slot(int s);
        if (mode_tab[s] == psts_pkg::MODE_MULTI)
            return;
        if (mode_tab[s] == psts_pkg::MODE_EMPTY)
            tgt_cnt[s] = 0;
        mrk_cnt[s] = 0;
        mode_tab[s] = psts_pkg::MODE_MULTI;
        multi_cnt++;
    endfunction

    // work out the answer to one request and update the table
    function automatic answer_t table_answer(request_t r);
        answer_t a;
        int s;
        int n;
        bit hit;
        a = '0;
        s = int'(r.symbol);
        hit = 1'b0;
        case (r.command)
            psts_pkg::CMD_ADD_TARGET:
            begin
                if (mode_tab[s] == psts_pkg::MODE_EMPTY)
                begin
                    tgt_tab[s][0] = r.target_value;
                    tgt_cnt[s] = 1;
                    mode_tab[s] = psts_pkg::MODE_SINGLE;
                    a.ok = 1'b1;
                end
                else if (mode_tab[s] == psts_pkg::MODE_SINGLE)
                begin
                    a.ok = 1'b1;
                    if (tgt_tab[s][0] != r.target_value)
                    begin
                        tgt_tab[s][1] = r.target_value;
                        tgt_cnt[s] = 2;
                        mrk_cnt[s] = 0;
                        mode_tab[s] = psts_pkg::MODE_MULTI;
                        multi_cnt++;
                    end
                end
                else
                begin
                    for (int i = 0; i < tgt_cnt[s]; i++)
                        if (tgt_tab[s][i] == r.target_value)
                            hit = 1'b1;
                    if (hit)
                        a.ok = 1'b1;
                    else if (tgt_cnt[s] < NTGT)
                    begin
                        tgt_tab[s][tgt_cnt[s]] = r.target_value;
                        tgt_cnt[s]++;
                        a.ok = 1'b1;
                    end
                end
                a.count = 5'(tgt_cnt[s]);
            end
            psts_pkg::CMD_ADD_MARKER:
            begin
                if (r.marker_kind <= 8'd1)
                begin
                    upgrade_slot(s);
                    for (int i = 0; i < mrk_cnt[s]; i++)
                        if (mrk_pat[s][i] == r.pattern && mrk_uid[s][i] == r.marker_uid
                            && mrk_knd[s][i] == r.marker_kind[0])
                            hit = 1'b1;
                    if (hit)
                        a.ok = 1'b1;
                    else if (mrk_cnt[s] < NMRK)
                    begin
                        mrk_pat[s][mrk_cnt[s]] = r.pattern;
                        mrk_uid[s][mrk_cnt[s]] = r.marker_uid;
                        mrk_knd[s][mrk_cnt[s]] = r.marker_kind[0];
                        mrk_cnt[s]++;
                        a.ok = 1'b1;
                    end
                end
                a.count = 5'(mrk_cnt[s]);
            end
            psts_pkg::CMD_CLR_SYMBOL:
            begin
                if (mode_tab[s] == psts_pkg::MODE_MULTI)
                    multi_cnt--;
                mode_tab[s] = psts_pkg::MODE_EMPTY;
                tgt_cnt[s] = 0;
                mrk_cnt[s] = 0;
                a.ok = 1'b1;
            end
            psts_pkg::CMD_CLR_MARKERS:
            begin
                if (mode_tab[s] == psts_pkg::MODE_MULTI)
                    mrk_cnt[s] = 0;
                a.ok = 1'b1;
            end
            psts_pkg::CMD_RD_TARGET:
            begin
                n = (mode_tab[s] == psts_pkg::MODE_EMPTY) ? 0 : tgt_cnt[s];
                a.count = 5'(n);
                if (int'(r.element_index) < n)
                begin
                    a.ok = 1'b1;
                    a.read_target = tgt_tab[s][r.element_index];
                end
            end
            psts_pkg::CMD_RD_MARKER:
            begin
                n = (mode_tab[s] == psts_pkg::MODE_MULTI) ? mrk_cnt[s] : 0;
                a.count = 5'(n);
                if (int'(r.element_index) < n)
                begin
                    a.ok = 1'b1;
                    a.read_pattern = mrk_pat[s][r.element_index];
                    a.read_uid = mrk_uid[s][r.element_index];
                    a.read_kind = mrk_knd[s][r.element_index];
                end
            end
            default: ;
        endcase
        a.is_multi = (mode_tab[s] == psts_pkg::MODE_MULTI);
        a.multi_entries = 9'(multi_cnt);
        return a;
    endfunction

    // offer one request, with an optional random gap first
    task automatic send_request(request_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= psts_pkg::IN_TDATA_W'(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_answers.push_back(table_answer(r));
    endtask

    // drop valid and wait on the clock
    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic request_t make_req(logic [2:0] c, int s);
        request_t r;
        r = '0;
        r.command = c;
        r.symbol = 8'(s);
        r.target_value = 16'($urandom);
        r.pattern = 16'($urandom);
        r.marker_uid = $urandom;
        r.marker_kind = 8'($urandom_range(0, 1));
        r.element_index = 4'($urandom);
        return r;
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (idle_on && $urandom_range(0, 5) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp_a;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = answer_t'(m_tdata[80:0]);
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_a = expected_answers.pop_front();
                if (got !== exp_a || m_tdata[87:81] !== 7'd0)
                begin
                    $display({"%0t: expected ok=%0d count=%0d rt=%h rp=%h ru=%h",
                              " rk=%0d m=%0d me=%0d"},
                             $time, exp_a.ok, exp_a.count, exp_a.read_target,
                             exp_a.read_pattern, exp_a.read_uid, exp_a.read_kind,
                             exp_a.is_multi, exp_a.multi_entries);
                    $display({"%0t: actual   ok=%0d count=%0d rt=%h rp=%h ru=%h",
                              " rk=%0d m=%0d me=%0d"},
                             $time, got.ok, got.count, got.read_target,
                             got.read_pattern, got.read_uid, got.read_kind,
                             got.is_multi, got.multi_entries);
                    errors++;
                end
            end
        end
    end

    // extremes, every command and the special cases
    task automatic test_directed();
        request_t r;
        r = make_req(psts_pkg::CMD_RD_TARGET, 0);       send_request(r);
        r = make_req(psts_pkg::CMD_RD_MARKER, 255);     send_request(r);
        r = make_req(psts_pkg::CMD_ADD_TARGET, 0); r.target_value = 16'hFFFF; send_request(r);
        r.target_value = 16'hFFFF;                      send_request(r);
        r = make_req(psts_pkg::CMD_RD_MARKER, 0);       send_request(r);
        r = make_req(psts_pkg::CMD_CLR_MARKERS, 0);     send_request(r);
        r = make_req(psts_pkg::CMD_ADD_TARGET, 0); r.target_value = 16'd0; send_request(r);
        r = make_req(psts_pkg::CMD_ADD_MARKER, 255); r.marker_kind = 8'hFF; send_request(r);
        r.marker_kind = 8'd2;                           send_request(r);
        r = make_req(psts_pkg::CMD_ADD_MARKER, 255); r.pattern = 16'hFFFF; r.marker_uid = '1;
        r.marker_kind = 8'd1;                           send_request(r);
        send_request(r);
        r = make_req(psts_pkg::CMD_RD_MARKER, 255); r.element_index = 4'd0; send_request(r);
        r.element_index = 4'hF;                         send_request(r);
        r = make_req(psts_pkg::CMD_RD_TARGET, 0); r.element_index = 4'd1; send_request(r);
        r = make_req(3'd6, 10);                         send_request(r);
        r = make_req(3'd7, 10);                         send_request(r);
        r = make_req(psts_pkg::CMD_ADD_TARGET, 7); r.target_value = 16'd5; send_request(r);
        r = make_req(psts_pkg::CMD_ADD_MARKER, 7); r.marker_kind = 8'd0; send_request(r);
        r = make_req(psts_pkg::CMD_RD_TARGET, 7); r.element_index = 4'd0; send_request(r);
        r = make_req(psts_pkg::CMD_CLR_MARKERS, 255);   send_request(r);
        r = make_req(psts_pkg::CMD_CLR_SYMBOL, 255);    send_request(r);
        r = make_req(psts_pkg::CMD_CLR_SYMBOL, 0);      send_request(r);
        go_quiet();
    endtask

    // fill target and marker lists past their limits
    task automatic test_full_lists();
        request_t r;
        for (int i = 0; i < NTGT + 3; i++)
        begin
            r = make_req(psts_pkg::CMD_ADD_TARGET, 128);
            r.target_value = 16'(i * 4099);
            send_request(r);
        end
        for (int i = 0; i < NMRK + 3; i++)
        begin
            r = make_req(psts_pkg::CMD_ADD_MARKER, 128); r.pattern = 16'(i); send_request(r);
        end
        for (int i = 0; i < 16; i++)
        begin
            r = make_req(psts_pkg::CMD_RD_TARGET, 128); r.element_index = 4'(i); send_request(r);
            r = make_req(psts_pkg::CMD_RD_MARKER, 128); r.element_index = 4'(i); send_request(r);
        end
        go_quiet();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        request_t r;
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++)
            begin
                r = make_req(3'($urandom_range(0, 5)), int'($urandom_range(0, 3)));
                send_request(r);
            end
        join
        go_quiet();
    endtask

    // random mix, mostly on a few busy slots so lists fill up
    task automatic test_random(int n);
        request_t r;
        int s;
        for (int i = 0; i < n; i++)
        begin
            if (i > n - 200)
                idle_on = 1'b0;
            s = ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 7))
                                           : int'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:   r = make_req(psts_pkg::CMD_ADD_TARGET, s);
                6, 7, 8, 9:         r = make_req(psts_pkg::CMD_ADD_MARKER, s);
                10:                 r = make_req(psts_pkg::CMD_CLR_SYMBOL, s);
                11:                 r = make_req(psts_pkg::CMD_CLR_MARKERS, s);
                12, 13, 14:         r = make_req(psts_pkg::CMD_RD_TARGET, s);
                15, 16, 17:         r = make_req(psts_pkg::CMD_RD_MARKER, s);
                default:            r = make_req(3'($urandom_range(0, 7)), s);
            endcase
            // small value pools so duplicates are common
            if ($urandom_range(0, 3) != 0)
            begin
                r.target_value = 16'($urandom_range(0, 20));
                r.pattern = 16'($urandom_range(0, 3));
                r.marker_uid = $urandom_range(0, 2);
            end
            if ($urandom_range(0, 15) == 0)
                r.marker_kind = 8'($urandom);
            send_request(r);
        end
        go_quiet();
    endtask

    initial
    begin
        for (int i = 0; i < NSYM; i++)
        begin
            mode_tab[i] = psts_pkg::MODE_EMPTY;
            tgt_cnt[i] = 0;
            mrk_cnt[i] = 0;
        end
        multi_cnt = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_lists();
        test_backpressure();
        test_random(1500);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
